FILE: src/cpl_pkg.sv
// ----------------------------------------------------------------------------
// cpl_pkg
// Shared types and codes for the compacting position list.
// ----------------------------------------------------------------------------
package cpl_pkg;

	typedef logic [2:0] mode_t;

	localparam mode_t MODE_APPEND = 3'd0;
	localparam mode_t MODE_DELETE = 3'd1;
	localparam mode_t MODE_UPDATE = 3'd2;
	localparam mode_t MODE_READ   = 3'd3;
	localparam mode_t MODE_CLEAR  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_item;
		logic set_err;
		logic do_append;
		logic do_update;
		logic do_read;
		logic do_clear;
		logic start_shift;
		logic shift_step;
		logic dec_count;
		logic load_result;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  pos_ok;
		logic  has_room;
		logic  shift_rd;
		logic  shift_pend;
		logic  out_free;
	} stat_t;

endpackage

FILE: src/cpl_ctrl.sv
// ----------------------------------------------------------------------------
// cpl_ctrl
// Sequencer: decodes the held item and steps the datapath through it.
// ----------------------------------------------------------------------------
module cpl_ctrl import cpl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  stat_t  st,
	output cmd_t   cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (st.mode == MODE_DELETE && st.pos_ok) state_nxt = ST_SHIFT;
				else state_nxt = ST_FINISH;
			end
			ST_SHIFT: begin
				if (!st.shift_rd && !st.shift_pend) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (st.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_EXEC: begin
				unique case (st.mode)
					MODE_APPEND: begin
						cmd.do_append = st.has_room;
						cmd.set_err   = !st.has_room;
					end
					MODE_DELETE: begin
						cmd.start_shift = st.pos_ok;
						cmd.set_err     = !st.pos_ok;
					end
					MODE_UPDATE: begin
						cmd.do_update = st.pos_ok;
						cmd.set_err   = !st.pos_ok;
					end
					MODE_READ: begin
						cmd.do_read = st.pos_ok;
						cmd.set_err = !st.pos_ok;
					end
					MODE_CLEAR: begin
						cmd.do_clear = 1'b1;
					end
					default: begin
						cmd.set_err = 1'b1;
					end
				endcase
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				cmd.dec_count  = !st.shift_rd && !st.shift_pend;
			end
			ST_FINISH: begin
				cmd.load_result = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: src/cpl_dpath.sv
// ----------------------------------------------------------------------------
// cpl_dpath
// Item holding registers, entry memory, count, shift pointer, result register.
// ----------------------------------------------------------------------------
module cpl_dpath import cpl_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [2:0]                    mode,
	input  logic [$clog2(DEPTH+1)-1:0]    position,
	input  logic [DATA_WIDTH-1:0]         entry_data,
	input  logic                          cfg_wr_en,
	input  logic [$clog2(DEPTH+1)-1:0]    cfg_wr_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          status,
	output logic [DATA_WIDTH-1:0]         read_data,
	output logic [$clog2(DEPTH+1)-1:0]    count,
	output logic                          is_full,
	output logic                          is_empty,
	input  cmd_t                          cmd,
	output stat_t                         st
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] CAP_RST = CW'((DEPTH < 64) ? DEPTH : 64);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	mode_t                 mode_q;
	logic [CW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [CW-1:0]         cap_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         ptr_q;
	logic [AW-1:0]         wr_idx_s1;
	logic                  pend_q;
	logic                  err_q;
	logic                  rsel_q;
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic                  out_valid_q;
	logic                  status_q;
	logic [DATA_WIDTH-1:0] read_data_q;
	logic [CW-1:0]         count_out_q;
	logic                  full_q;
	logic                  empty_q;

	logic [CW-1:0]         cap_eff;
	logic [CW-1:0]         pos_m1;
	logic [CW-1:0]         ptr_m1;
	logic                  shift_rd;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [DATA_WIDTH-1:0] mem_wd;
	logic                  mem_re;
	logic [AW-1:0]         mem_ra;

	// zero acts as one, anything above the memory depth acts as the depth
	always_comb begin
		if (cap_q == '0) cap_eff = CW'(1);
		else if (cap_q > DEPTH_C) cap_eff = DEPTH_C;
		else cap_eff = cap_q;
	end

	assign pos_m1   = pos_q - CW'(1);
	assign ptr_m1   = ptr_q - CW'(1);
	assign shift_rd = ptr_q < count_q;

	assign st.mode       = mode_q;
	assign st.pos_ok     = (pos_q != '0) && (pos_q <= count_q);
	assign st.has_room   = count_q < cap_eff;
	assign st.shift_rd   = shift_rd;
	assign st.shift_pend = pend_q;
	assign st.out_free   = !out_valid_q || out_ready;

	// memory port steering
	always_comb begin
		mem_we = 1'b0;
		mem_wa = count_q[AW-1:0];
		mem_wd = data_q;
		if (cmd.do_append) begin
			mem_we = 1'b1;
		end else if (cmd.do_update) begin
			mem_we = 1'b1;
			mem_wa = pos_m1[AW-1:0];
		end else if (cmd.shift_step && pend_q) begin
			mem_we = 1'b1;
			mem_wa = wr_idx_s1;
			mem_wd = rd_data_q;
		end
		mem_re = cmd.do_read || (cmd.shift_step && shift_rd);
		mem_ra = cmd.do_read ? pos_m1[AW-1:0] : ptr_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rd_data_q <= mem[mem_ra];
	end

	// item holding and result flags
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q <= mode;
			pos_q  <= position;
			data_q <= entry_data;
			err_q  <= 1'b0;
			rsel_q <= 1'b0;
		end else begin
			if (cmd.set_err) err_q <= 1'b1;
			if (cmd.do_read) rsel_q <= 1'b1;
		end
		if (cmd.shift_step && shift_rd) wr_idx_s1 <= ptr_m1[AW-1:0];
		if (cmd.load_result) begin
			status_q    <= err_q;
			read_data_q <= rsel_q ? rd_data_q : '0;
			count_out_q <= count_q;
			full_q      <= count_q >= cap_eff;
			empty_q     <= count_q == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RST;
			count_q     <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) cap_q <= cfg_wr_data;

			if (cmd.do_append) count_q <= count_q + CW'(1);
			else if (cmd.do_clear) count_q <= '0;
			else if (cmd.dec_count) count_q <= count_q - CW'(1);

			// entry at position+1 sits at zero-based index position
			if (cmd.start_shift) begin
				ptr_q  <= pos_q;
				pend_q <= 1'b0;
			end else if (cmd.shift_step) begin
				if (shift_rd) ptr_q <= ptr_q + CW'(1);
				pend_q <= shift_rd;
			end

			if (cmd.load_result) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign read_data = read_data_q;
	assign count     = count_out_q;
	assign is_full   = full_q;
	assign is_empty  = empty_q;

endmodule

FILE: src/compacting_position_list.sv
// ----------------------------------------------------------------------------
// compacting_position_list
// Fixed-capacity ordered list, 1-based positions, append/delete/update/read/
// clear, with delete compacting the tail down one place.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------
//  in        in_valid / in_ready    mode, position, entry_data
//  out       out_valid / out_ready  status, read_data, count, is_full,
//                                   is_empty
//  cfg       cfg_wr_en (no stall)   cfg_wr_data = capacity
//
//  One item at a time. Append, update, read, clear and rejected items pass
//  through accept, execute and finish before the result is loaded.
//  A delete at position p with count n adds a shift through the single entry
//  RAM: one word per cycle, ending once the last moved word is written back.
//  The result sits in an output register; the next item is accepted while it
//  waits, and only the finish step stalls on a full output register.
//  Reset clears count, capacity (64, clamped to DEPTH) and all control state;
//  the entry RAM is not cleared and is never read before written.
//
module compacting_position_list import cpl_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    mode,
	input  logic [$clog2(DEPTH+1)-1:0]    position,
	input  logic [DATA_WIDTH-1:0]         entry_data,
	// capacity register
	input  logic                          cfg_wr_en,
	input  logic [$clog2(DEPTH+1)-1:0]    cfg_wr_data,
	// result
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic [DATA_WIDTH-1:0]         read_data,
	output logic [$clog2(DEPTH+1)-1:0]    count,
	output logic                          is_full,
	output logic                          is_empty
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	cmd_t  cmd;
	stat_t st;

	// sequencer
	cpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// storage, count, shifter and result register
	cpl_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.position    (position),
		.entry_data  (entry_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.read_data   (read_data),
		.count       (count),
		.is_full     (is_full),
		.is_empty    (is_empty),
		.cmd         (cmd),
		.st          (st)
	);

	// block is busy right after taking an item
	a_busy_after_accept: assert property (
		@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready
	) else $error("request taken while previous item still in work");

	// reported count never beyond the storage depth
	a_count_bound: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= DEPTH_C)
	) else $error("count exceeds depth");

	// effective capacity is at least one, so full and empty never coincide
	a_full_empty: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_full && is_empty)
	) else $error("full and empty both set");

	// a failed request returns no data
	a_err_no_data: assert property (
		@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (read_data == '0)
	) else $error("error result carries read data");

endmodule
